// File: hdl/sht_pkg.sv
// Shared types, constants and the microcode program of the scheduled thermostat.
package sht_pkg;

   localparam int DEF_DAYS   = 7;
   localparam int DEF_SLOTS  = 6;
   localparam int TEMP_W     = 12;
   localparam int TCODE_W    = 12;
   localparam int TIME_SCALE = 100;
   localparam logic [TCODE_W-1:0] TIME_END = TCODE_W'(2359);

   // Configuration register indexes.
   localparam logic [2:0] CSR_ENABLE  = 3'd0;
   localparam logic [2:0] CSR_MODE    = 3'd1;
   localparam logic [2:0] CSR_MANUAL  = 3'd2;
   localparam logic [2:0] CSR_IDLE    = 3'd3;
   localparam logic [2:0] CSR_HYST    = 3'd4;

   // Operating modes.
   localparam logic [2:0] MODE_NONE   = 3'd0;
   localparam logic [2:0] MODE_AUTO   = 3'd1;
   localparam logic [2:0] MODE_MANUAL = 3'd2;
   localparam logic [2:0] MODE_OFF    = 3'd3;
   localparam logic [2:0] MODE_IDLE   = 3'd4;

   localparam logic signed [TEMP_W-1:0] MANUAL_RESET = TEMP_W'(200);
   localparam logic signed [TEMP_W-1:0] IDLE_RESET   = TEMP_W'(50);
   localparam logic [6:0]               HYST_RESET   = 7'd5;

   typedef struct packed {
      logic                     cmd;
      logic [2:0]               day;
      logic [2:0]               slot;
      logic [4:0]               hour;
      logic [5:0]               minute;
      logic signed [TEMP_W-1:0] temperature;
   } sht_req_type;

   typedef struct packed {
      logic                     relay_on;
      logic [2:0]               active_slot;
      logic signed [TEMP_W-1:0] active_target;
      logic                     matched;
   } sht_rsp_type;

   typedef struct packed {
      logic [TCODE_W-1:0]       start_code;
      logic signed [TEMP_W-1:0] target;
   } entry_type;

   typedef logic [2:0] step_type;

   localparam step_type STEP_IDLE     = 3'd0;
   localparam step_type STEP_DISPATCH = 3'd1;
   localparam step_type STEP_LOOP     = 3'd2;
   localparam step_type STEP_DRAIN    = 3'd3;
   localparam step_type STEP_LAST     = 3'd4;
   localparam step_type STEP_FINISH   = 3'd5;

   typedef enum logic [2:0] {
      COND_NEVER  = 3'd0,
      COND_ALWAYS = 3'd1,
      COND_WAIT   = 3'd2,
      COND_SKIP   = 3'd3,
      COND_MORE   = 3'd4
   } cond_type;

   typedef struct packed {
      logic     rd;
      logic     k_init;
      logic     k_inc;
      logic     shift;
      logic     eval_pair;
      logic     eval_last;
      logic     wr;
      logic     respond;
      cond_type cond;
      step_type target;
   } ctl_type;

   typedef struct packed {
      logic start;
      logic skip;
      logic more;
   } flags_type;

   // Control store: one word per step.
   function automatic ctl_type sht_ucode(input step_type step);
      ctl_type w;
      w = '0;
      w.cond   = COND_NEVER;
      w.target = STEP_IDLE;
      case (step)
         STEP_IDLE: begin
            w.cond   = COND_WAIT;
            w.target = STEP_IDLE;
         end
         STEP_DISPATCH: begin
            w.rd     = 1'b1;
            w.k_init = 1'b1;
            w.cond   = COND_SKIP;
            w.target = STEP_FINISH;
         end
         STEP_LOOP: begin
            w.rd        = 1'b1;
            w.k_inc     = 1'b1;
            w.shift     = 1'b1;
            w.eval_pair = 1'b1;
            w.cond      = COND_MORE;
            w.target    = STEP_LOOP;
         end
         STEP_DRAIN: begin
            w.shift     = 1'b1;
            w.eval_pair = 1'b1;
         end
         STEP_LAST: begin
            w.eval_last = 1'b1;
            w.respond   = 1'b1;
            w.cond      = COND_ALWAYS;
            w.target    = STEP_IDLE;
         end
         STEP_FINISH: begin
            w.wr      = 1'b1;
            w.respond = 1'b1;
            w.cond    = COND_ALWAYS;
            w.target  = STEP_IDLE;
         end
         default: begin
            w.cond   = COND_ALWAYS;
            w.target = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

// File: hdl/sht_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sht_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 42
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: hdl/sht_seq.sv
// Microcode sequencer: step counter, control store lookup and conditional jumps.
module sht_seq
   import sht_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  flags_type flags,
   output ctl_type   ctl,
   output logic      busy
);

   step_type upc_ff;
   step_type upc_in;
   logic     taken;

   assign ctl  = sht_ucode(upc_ff);
   assign busy = (upc_ff != STEP_IDLE);

   always_comb begin
      case (ctl.cond)
         COND_NEVER:  taken = 1'b0;
         COND_ALWAYS: taken = 1'b1;
         COND_WAIT:   taken = ~flags.start;
         COND_SKIP:   taken = flags.skip;
         COND_MORE:   taken = flags.more;
         default:     taken = 1'b1;
      endcase
      upc_in = taken ? ctl.target : step_type'(upc_ff + 3'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= STEP_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

// File: hdl/scheduled_hysteresis_thermostat.sv
// Top level of the weekly scheduled thermostat with hysteresis relay control.
//
// Usage: an item is transferred on req_item at a clock edge where start is high
// and busy is low. A write item (cmd set) stores a slot start time and target
// in the schedule; a sample item walks the day's slots and drives the relay.
// Every item yields exactly one result on rsp_item, marked by rsp_valid for a
// single cycle; the receiver cannot stall, so it must take it in that cycle.
// The csr_ port writes configuration registers with no wait; write only while
// busy is low and no result is pending.
// Sequence: a sample's result is on rsp_item once the dispatch, loop, drain and
// last steps have run; a write's or a skipped sample's once the dispatch and finish
// steps have run. A new item is taken at the edge that ends the result cycle, so
// an item is not taken before the last one is through. The microcode loop reads
// one schedule entry per cycle from the schedule memory's single read port.
// Reset: schedule entries read as zero (a valid bit per entry), the relay is
// off, the active slot and target are zero and registers take their defaults.
module scheduled_hysteresis_thermostat
   import sht_pkg::*;
#(
   parameter int DAYS  = DEF_DAYS,
   parameter int SLOTS = DEF_SLOTS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  sht_req_type req_item,
   output logic        rsp_valid,
   output sht_rsp_type rsp_item,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [11:0] csr_wdata
);

   localparam int DEPTH = DAYS * SLOTS;
   localparam int AW    = $clog2(DEPTH);
   localparam int SW    = $clog2(SLOTS);

   // Configuration registers.
   logic                     enable_ff;
   logic [2:0]               mode_ff;
   logic signed [TEMP_W-1:0] manual_ff;
   logic signed [TEMP_W-1:0] idle_ff;
   logic [6:0]               hyst_ff;

   // Latched item.
   logic                     cmd_ff;
   logic [2:0]               day_ff;
   logic [2:0]               slot_ff;
   logic [TCODE_W-1:0]       now_ff;
   logic signed [TEMP_W-1:0] meas_ff;

   // Slot walk.
   logic [SW-1:0]            k_ff;
   logic [SW-1:0]            di_ff;
   entry_type                prev_ff;
   logic                     rd_valid_ff;
   logic [DEPTH-1:0]         valid_ff;

   // Thermostat state and result strobe.
   logic                     relay_ff, relay_in;
   logic [2:0]               last_slot_ff, last_slot_in;
   logic signed [TEMP_W-1:0] last_target_ff, last_target_in;
   logic                     hit_ff, hit_in;
   logic                     rsp_valid_ff;

   ctl_type                  ctl;
   flags_type                flags;
   logic                     accept;
   logic                     day_ok;
   logic                     wr_en;
   logic                     rd_en;
   logic [SW-1:0]            rd_slot;
   logic [AW-1:0]            waddr;
   logic [AW-1:0]            raddr;
   entry_type                wdata;
   entry_type                rdata;
   entry_type                cur;
   logic                     eval;
   logic                     match;
   logic [TCODE_W-1:0]       from_code;
   logic [TCODE_W-1:0]       to_code;
   logic signed [13:0]       meas_ext;
   logic signed [13:0]       hyst_ext;
   logic signed [13:0]       tgt_ext;
   logic signed [13:0]       upper;
   logic signed [13:0]       lower;
   logic signed [TEMP_W-1:0] tgt;
   logic [TCODE_W-1:0]       now_code;

   sht_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctl   (ctl),
      .busy  (busy)
   );

   sht_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (DEPTH)
   ) u_schedule (
      .clock (clock),
      .we    (wr_en),
      .waddr (waddr),
      .wdata (wdata),
      .re    (rd_en),
      .raddr (raddr),
      .rdata (rdata)
   );

   assign accept   = start & ~busy;
   assign day_ok   = int'(day_ff) < DAYS;
   assign now_code = TCODE_W'(int'(req_item.hour) * TIME_SCALE + int'(req_item.minute));

   assign flags.start = start;
   assign flags.skip  = cmd_ff | ~enable_ff | ~day_ok;
   assign flags.more  = (k_ff != SW'(SLOTS - 1));

   // Schedule access. Writes out of range are dropped.
   assign wr_en   = ctl.wr & cmd_ff & day_ok & (int'(slot_ff) < SLOTS);
   assign waddr   = AW'(int'(day_ff) * SLOTS + int'(slot_ff));
   assign wdata   = '{start_code: now_ff, target: meas_ff};
   assign rd_slot = ctl.k_init ? '0 : k_ff;
   assign rd_en   = ctl.rd & ~flags.skip;
   assign raddr   = AW'(int'(day_ff) * SLOTS + int'(rd_slot));
   assign cur     = rd_valid_ff ? rdata : '0;

   // Slot window: the pair steps check slot di-1 against the entry just read,
   // the last step checks the final slot against the end of the day.
   assign eval      = ctl.eval_last | (ctl.eval_pair & (di_ff != '0));
   assign from_code = (ctl.eval_pair && di_ff == SW'(1)) ? '0 : prev_ff.start_code;
   assign to_code   = ctl.eval_last ? TIME_END : cur.start_code;
   assign match     = eval & (from_code <= now_ff) & (now_ff <= to_code);

   always_comb begin
      case (mode_ff)
         MODE_AUTO:   tgt = prev_ff.target;
         MODE_MANUAL: tgt = manual_ff;
         default:     tgt = idle_ff;
      endcase
   end

   assign meas_ext = {{2{meas_ff[TEMP_W-1]}}, meas_ff};
   assign hyst_ext = {7'd0, hyst_ff};
   assign tgt_ext  = {{2{tgt[TEMP_W-1]}}, tgt};
   assign upper    = meas_ext + hyst_ext;
   assign lower    = meas_ext - hyst_ext;

   always_comb begin
      relay_in       = relay_ff;
      last_slot_in   = last_slot_ff;
      last_target_in = last_target_ff;
      hit_in         = hit_ff;
      if (accept) begin
         hit_in = 1'b0;
      end else if (match) begin
         hit_in         = 1'b1;
         last_target_in = prev_ff.target;
         last_slot_in   = ctl.eval_last ? 3'(SLOTS) : 3'(di_ff);
         if (mode_ff == MODE_OFF) begin
            relay_in = 1'b0;
         end else if (mode_ff inside {MODE_AUTO, MODE_MANUAL, MODE_IDLE}) begin
            // The turn-off test comes before the turn-on test and wins on a tie.
            if (lower >= tgt_ext) begin
               relay_in = 1'b0;
            end else if (upper <= tgt_ext) begin
               relay_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff      <= 1'b0;
         mode_ff        <= MODE_NONE;
         manual_ff      <= MANUAL_RESET;
         idle_ff        <= IDLE_RESET;
         hyst_ff        <= HYST_RESET;
         valid_ff       <= '0;
         relay_ff       <= 1'b0;
         last_slot_ff   <= 3'd0;
         last_target_ff <= '0;
         hit_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_ENABLE: enable_ff <= csr_wdata[0];
               CSR_MODE:   mode_ff   <= csr_wdata[2:0];
               CSR_MANUAL: manual_ff <= csr_wdata;
               CSR_IDLE:   idle_ff   <= csr_wdata;
               CSR_HYST:   hyst_ff   <= csr_wdata[6:0];
               default: ;
            endcase
         end
         if (wr_en) begin
            valid_ff[waddr] <= 1'b1;
         end
         relay_ff       <= relay_in;
         last_slot_ff   <= last_slot_in;
         last_target_ff <= last_target_in;
         hit_ff         <= hit_in;
         rsp_valid_ff   <= ctl.respond;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= req_item.cmd;
         day_ff  <= req_item.day;
         slot_ff <= req_item.slot;
         now_ff  <= now_code;
         meas_ff <= req_item.temperature;
      end
      if (ctl.k_init) begin
         k_ff <= SW'(1);
      end else if (ctl.k_inc) begin
         k_ff <= k_ff + SW'(1);
      end
      if (rd_en) begin
         di_ff       <= rd_slot;
         rd_valid_ff <= valid_ff[raddr];
      end
      if (ctl.shift) begin
         prev_ff <= cur;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_item.relay_on      = relay_ff;
   assign rsp_item.active_slot   = last_slot_ff;
   assign rsp_item.active_target = last_target_ff;
   assign rsp_item.matched       = hit_ff;

`ifndef SYNTHESIS
   // A result is only shown once the sequencer is back at its wait step.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> !busy)
      else $error("result strobe while the sequencer is busy");

   // A transfer always starts the program.
   assert property (@(posedge clock) disable iff (reset) (start && !busy) |=> busy)
      else $error("accepted item did not start the sequencer");

   // In off mode a matched sample leaves the relay off.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.matched && mode_ff == MODE_OFF) |-> !rsp_item.relay_on)
      else $error("relay on after a match in off mode");

   // Write items never report a slot match.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && cmd_ff) |-> !rsp_item.matched)
      else $error("write item reported a match");
`endif

endmodule

// File: bench/tb_scheduled_hysteresis_thermostat.sv
// Self-checking testbench for the scheduled hysteresis thermostat.
`timescale 1ns / 1ps

module tb_scheduled_hysteresis_thermostat;
   import sht_pkg::*;

   localparam logic       CMD_SAMPLE       = 1'b0;
   localparam logic       CMD_WRITE        = 1'b1;
   localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
   localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;
   localparam int         WATCHDOG_LIMIT   = 2000;
   localparam int         TEMP_MIN         = -2048;
   localparam int         TEMP_MAX         = 2047;

   logic        clock;
   logic        reset     = 1'b1;
   logic        start     = 1'b0;
   logic        busy;
   sht_req_type req_item  = '0;
   logic        rsp_valid;
   sht_rsp_type rsp_item;
   logic        csr_we    = 1'b0;
   logic [2:0]  csr_index = CSR_ENABLE;
   logic [11:0] csr_wdata = '0;

   scheduled_hysteresis_thermostat u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   sht_req_type pending_cmds[$];
   sht_rsp_type expected_status[$];
   int          sender_idle_pct = 0;
   int          error_count     = 0;
   int          quiet_cycles    = 0;

   // Shadow of the block: schedule, relay state and registers.
   logic [TCODE_W-1:0]       sched_code   [DEF_DAYS][DEF_SLOTS] = '{default: '0};
   logic signed [TEMP_W-1:0] sched_target [DEF_DAYS][DEF_SLOTS] = '{default: '0};
   logic                     relay_q  = 1'b0;
   logic [2:0]               slot_q   = '0;
   logic signed [TEMP_W-1:0] target_q = '0;
   logic                     cfg_enable = 1'b0;
   logic [2:0]               cfg_mode   = MODE_NONE;
   int                       cfg_manual = MANUAL_RESET;
   int                       cfg_idle   = IDLE_RESET;
   int                       cfg_hyst   = HYST_RESET;

   // Start codes of the schedule as the stimulus has written it so far.
   int plan_code [DEF_DAYS][DEF_SLOTS] = '{default: 0};

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic void apply_band(int meas, int goal);
      if (meas + cfg_hyst <= goal) relay_q = 1'b1;
      if (meas - cfg_hyst >= goal) relay_q = 1'b0;
   endfunction

   function automatic sht_rsp_type predict_thermostat(sht_req_type cmd);
      sht_rsp_type status;
      int          now, lo, hi, meas;
      logic        hit;
      hit  = 1'b0;
      now  = int'(cmd.hour) * TIME_SCALE + int'(cmd.minute);
      meas = $signed(cmd.temperature);
      if (cmd.cmd == CMD_WRITE) begin
         if (cmd.day < DEF_DAYS && cmd.slot < DEF_SLOTS) begin
            sched_code[cmd.day][cmd.slot]   = TCODE_W'(now);
            sched_target[cmd.day][cmd.slot] = cmd.temperature;
         end
      end else if (cfg_enable && cmd.day < DEF_DAYS) begin
         for (int k = 0; k < DEF_SLOTS; k++) begin
            lo = (k == 0) ? 0 : int'(sched_code[cmd.day][k]);
            if (k == DEF_SLOTS - 1)
               hi = int'(TIME_END);
            else
               hi = int'(sched_code[cmd.day][k + 1]);
            if (lo <= now && now <= hi) begin
               hit      = 1'b1;
               slot_q   = 3'(k + 1);
               target_q = sched_target[cmd.day][k];
               case (cfg_mode)
                  MODE_AUTO:   apply_band(meas, $signed(target_q));
                  MODE_MANUAL: apply_band(meas, cfg_manual);
                  MODE_OFF:    relay_q = 1'b0;
                  MODE_IDLE:   apply_band(meas, cfg_idle);
                  default: ;
               endcase
            end
         end
      end
      status.relay_on      = relay_q;
      status.active_slot   = slot_q;
      status.active_target = target_q;
      status.matched       = hit;
      return status;
   endfunction

   // Driver: a command is transferred on an edge with start high and busy low.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_status.push_back(predict_thermostat(req_item));
            void'(pending_cmds.pop_front());
         end
         if (!start || !busy) begin
            if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
               start    <= 1'b1;
               req_item <= pending_cmds[0];
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   function automatic void flag_mismatch(string field, int want, int got);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      error_count++;
   endfunction

   // Monitor: every result is present for exactly one cycle.
   always @(posedge clock) begin : monitor
      sht_rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_status.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %p", $time, rsp_item);
            error_count++;
         end else begin
            want = expected_status.pop_front();
            if (rsp_item.relay_on !== want.relay_on)
               flag_mismatch("relay_on", want.relay_on, rsp_item.relay_on);
            if (rsp_item.active_slot !== want.active_slot)
               flag_mismatch("active_slot", want.active_slot, rsp_item.active_slot);
            if (rsp_item.active_target !== want.active_target)
               flag_mismatch("active_target", $signed(want.active_target),
                             $signed(rsp_item.active_target));
            if (rsp_item.matched !== want.matched)
               flag_mismatch("matched", want.matched, rsp_item.matched);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: timeout, no transfer for %0d cycles", $time, quiet_cycles);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic void push_cmd(logic c, int d, int s, int h, int m, int t);
      sht_req_type cmd;
      cmd.cmd         = c;
      cmd.day         = 3'(d);
      cmd.slot        = 3'(s);
      cmd.hour        = 5'(h);
      cmd.minute      = 6'(m);
      cmd.temperature = TEMP_W'(t);
      pending_cmds.push_back(cmd);
      if (c == CMD_WRITE && d < DEF_DAYS && s < DEF_SLOTS)
         plan_code[d][s] = h * TIME_SCALE + m;
   endfunction

   function automatic int pick_target(int center);
      int sel;
      sel = $urandom_range(0, 4);
      if (sel == 0) return TEMP_MIN;
      if (sel == 1) return TEMP_MAX;
      return center + int'($urandom_range(0, 120)) - 60;
   endfunction

   // Mostly samples around the phase's center temperature, with whole-day
   // schedules of rising start times and some unconstrained writes mixed in.
   function automatic void fill_random(int n, int center);
      int count, sel, d, t, h, m, k, temp;
      count = 0;
      while (count < n) begin
         sel = $urandom_range(0, 99);
         if (sel < 6) begin
            d = $urandom_range(0, DEF_DAYS - 1);
            t = $urandom_range(0, 60);
            for (k = 0; k < DEF_SLOTS; k++) begin
               push_cmd(CMD_WRITE, d, k, t / 60, t % 60,
                        center + int'($urandom_range(0, 60)) - 30);
               t = t + $urandom_range(0, 300);
               if (t > 1439) t = 1439;
            end
            count += DEF_SLOTS;
         end else if (sel < 10) begin
            push_cmd(CMD_WRITE, $urandom_range(0, 7), $urandom_range(0, 7),
                     $urandom_range(0, 31), $urandom_range(0, 63),
                     int'($urandom_range(0, 4095)) + TEMP_MIN);
            count++;
         end else begin
            d   = ($urandom_range(0, 19) == 0) ? DEF_DAYS : $urandom_range(0, DEF_DAYS - 1);
            sel = $urandom_range(0, 9);
            if (sel < 3 && d < DEF_DAYS) begin
               // Land exactly on a slot boundary.
               k = $urandom_range(0, DEF_SLOTS - 1);
               h = plan_code[d][k] / TIME_SCALE;
               m = plan_code[d][k] % TIME_SCALE;
            end else if (sel == 3) begin
               h = $urandom_range(0, 31);
               m = $urandom_range(0, 63);
            end else begin
               h = $urandom_range(0, 23);
               m = $urandom_range(0, 59);
            end
            if ($urandom_range(0, 9) == 0)
               temp = int'($urandom_range(0, 4095)) + TEMP_MIN;
            else
               temp = center + int'($urandom_range(0, 200)) - 100;
            push_cmd(CMD_SAMPLE, d, $urandom_range(0, 7), h, m, temp);
            count++;
         end
      end
   endfunction

   task automatic wait_drained();
      do
         @(negedge clock);
      while (pending_cmds.size() != 0 || expected_status.size() != 0 || start || busy);
   endtask

   task automatic new_phase(logic en, logic [2:0] md, int man, int idl, int hy, int idle_pct);
      wait_drained();
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_ENABLE;
      csr_wdata <= 12'(en);
      cfg_enable = en;
      @(posedge clock);
      csr_index <= CSR_MODE;
      csr_wdata <= 12'(md);
      cfg_mode   = md;
      @(posedge clock);
      csr_index <= CSR_MANUAL;
      csr_wdata <= 12'(man);
      cfg_manual = $signed(12'(man));
      @(posedge clock);
      csr_index <= CSR_IDLE;
      csr_wdata <= 12'(idl);
      cfg_idle   = $signed(12'(idl));
      @(posedge clock);
      csr_index <= CSR_HYST;
      csr_wdata <= 12'(hy);
      cfg_hyst   = hy;
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      sender_idle_pct = idle_pct;
   endtask

   initial begin : stimulus
      logic [2:0] modes [8];
      int         idles [8];
      int         hysts [8];
      int         center;
      modes = '{MODE_AUTO, MODE_MANUAL, MODE_AUTO, MODE_IDLE,
                MODE_AUTO, MODE_OFF, MODE_MANUAL, MODE_SPARE_FIRST};
      idles = '{0, 60, 0, 37, 60, 37, 0, 60};
      hysts = '{0, 127, 100, 5, 1, 20, 60, 10};

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Registers at reset: relay updates are off, writes out of range are dropped.
      push_cmd(CMD_SAMPLE, 0, 0, 0, 0, TEMP_MIN);
      push_cmd(CMD_WRITE, 6, 5, 23, 59, TEMP_MAX);
      push_cmd(CMD_WRITE, DEF_DAYS, 0, 12, 0, 100);
      push_cmd(CMD_WRITE, 0, DEF_SLOTS, 12, 0, 100);
      push_cmd(CMD_WRITE, 0, 7, 31, 63, TEMP_MIN);

      // Zero hysteresis; an empty day makes every slot match at midnight.
      new_phase(1'b1, MODE_AUTO, -550, 1250, 0, 0);
      push_cmd(CMD_SAMPLE, 0, 7, 0, 0, 0);
      push_cmd(CMD_SAMPLE, 0, 3, 12, 0, -10);
      push_cmd(CMD_SAMPLE, DEF_DAYS, 0, 12, 0, -10);
      push_cmd(CMD_SAMPLE, 0, 0, 31, 63, -10);
      push_cmd(CMD_SAMPLE, 0, 0, 23, 59, 500);
      push_cmd(CMD_WRITE, 1, 1, 6, 0, 210);
      push_cmd(CMD_WRITE, 1, 2, 8, 30, 180);
      push_cmd(CMD_WRITE, 1, 3, 12, 0, 200);
      push_cmd(CMD_WRITE, 1, 4, 17, 45, 220);
      push_cmd(CMD_WRITE, 1, 5, 22, 0, 160);
      push_cmd(CMD_SAMPLE, 1, 0, 8, 30, 100);
      push_cmd(CMD_SAMPLE, 1, 0, 23, 0, 250);

      new_phase(1'b1, MODE_MANUAL, -550, 1250, 100, 0);
      push_cmd(CMD_SAMPLE, 1, 0, 10, 0, -550);
      push_cmd(CMD_SAMPLE, 1, 0, 10, 0, 1250);

      new_phase(1'b1, MODE_IDLE, -550, 1250, 127, 0);
      push_cmd(CMD_SAMPLE, 1, 0, 5, 0, TEMP_MIN);

      new_phase(1'b1, MODE_OFF, 200, 50, 5, 0);
      push_cmd(CMD_SAMPLE, 1, 0, 5, 0, TEMP_MIN);
      push_cmd(CMD_WRITE, 2, 3, 9, 15, -550);

      new_phase(1'b1, MODE_SPARE_LAST, 200, 50, 5, 0);
      push_cmd(CMD_SAMPLE, 6, 0, 23, 59, 0);

      new_phase(1'b1, MODE_NONE, TEMP_MAX, TEMP_MIN, 5, 0);
      push_cmd(CMD_SAMPLE, 6, 0, 23, 59, TEMP_MAX);

      for (int p = 0; p < 8; p++) begin
         center = int'($urandom_range(0, 1800)) - 550;
         if (p == 7)
            modes[p] = 3'($urandom_range(0, 7));
         new_phase($urandom_range(0, 7) != 0, modes[p], pick_target(center),
                   pick_target(center), hysts[p], idles[p]);
         fill_random(112, center);
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
